>>> rtl/core/ttw_pkg.sv
// Package for the text terminal writer: screen geometry, field widths,
// register indexes and the micro-operation carried from front to back.
// No dependencies.
package ttw_pkg;

   // Screen geometry
   localparam int SCR_COLS = 80;
   localparam int SCR_ROWS = 25;
   localparam int CELL_CNT = SCR_COLS * SCR_ROWS;

   // Field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int IDX_W  = 11;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int CLR_W  = 8;
   localparam int SCRL_W = 5;

   // Reset values and fixed characters
   localparam logic [CLR_W-1:0]  RESET_COLOR  = 8'h06;
   localparam logic [SCRL_W-1:0] RESET_SCROLL = 5'd3;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] ERASE_CHAR   = 8'h00;

   // Configuration register indexes
   localparam logic CSR_TEXT_COLOR   = 1'b0;
   localparam logic CSR_SCROLL_LINES = 1'b1;

   // Queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACK,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [IDX_W-1:0]    cell_index;
      logic                last;
   } uop_type;

endpackage

>>> rtl/core/ttw_front.sv
// Front end: takes input beats, classifies each byte and splits an escaped
// byte into four print operations. Depends on ttw_pkg.
module ttw_front
   import ttw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,   // char_code[7:0], cell_index[18:8]
   input  logic               req_tuser,   // mode
   output logic               push_vld,
   input  logic               push_rdy,
   output uop_type            push_data
);

   logic                hold_vld_ff, hold_vld_in;
   logic                hold_mode_ff, hold_mode_in;
   logic [CHAR_W-1:0]   hold_char_ff, hold_char_in;
   logic [IDX_W-1:0]    hold_idx_ff, hold_idx_in;
   logic [1:0]          step_ff, step_in;
   logic                printable;
   logic                escaped;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] res;
      if (nib < 4'd10) begin
         res = 8'h30 + {4'h0, nib};
      end else begin
         res = 8'h57 + {4'h0, nib};
      end
      return res;
   endfunction

   assign printable = (hold_char_ff >= 8'h20) && (hold_char_ff <= 8'h7E);

   // Classify the held byte
   always_comb begin
      push_data.op         = OP_PRINT;
      push_data.char_code  = hold_char_ff;
      push_data.cell_index = hold_idx_ff;
      push_data.last       = 1'b1;
      escaped              = 1'b0;
      if (hold_mode_ff) begin
         push_data.op = OP_READ;
      end else begin
         case (hold_char_ff)
            8'h0A: push_data.op = OP_NEWLINE;
            8'h0D: push_data.op = OP_RETURN;
            8'h08: push_data.op = OP_BACK;
            default: begin
               if (!printable) begin
                  escaped = 1'b1;
               end
            end
         endcase
      end
      if (escaped) begin
         push_data.last = (step_ff == 2'd3);
         case (step_ff)
            2'd0:    push_data.char_code = 8'h5C;
            2'd1:    push_data.char_code = 8'h78;
            2'd2:    push_data.char_code = hex_char(hold_char_ff[7:4]);
            default: push_data.char_code = hex_char(hold_char_ff[3:0]);
         endcase
      end
   end

   assign push_vld   = hold_vld_ff;
   assign req_tready = enable && (!hold_vld_ff || (push_rdy && push_data.last));

   // Advance the split and load the next beat
   always_comb begin
      hold_vld_in  = hold_vld_ff;
      hold_mode_in = hold_mode_ff;
      hold_char_in = hold_char_ff;
      hold_idx_in  = hold_idx_ff;
      step_in      = step_ff;
      if (hold_vld_ff && push_rdy) begin
         if (push_data.last) begin
            hold_vld_in = 1'b0;
            step_in     = 2'd0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
      if (req_tvalid && req_tready) begin
         hold_vld_in  = 1'b1;
         hold_mode_in = req_tuser;
         hold_char_in = req_tdata[7:0];
         hold_idx_in  = req_tdata[18:8];
         step_in      = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         step_ff     <= 2'd0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         step_ff     <= step_in;
      end
      hold_mode_ff <= hold_mode_in;
      hold_char_ff <= hold_char_in;
      hold_idx_ff  <= hold_idx_in;
   end

endmodule

>>> rtl/core/ttw_queue.sv
// Short queue of micro-operations between front and back.
// Depends on ttw_pkg.
module ttw_queue
   import ttw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_vld,
   output logic     push_rdy,
   input  uop_type  push_data,
   output logic     pop_vld,
   input  logic     pop_rdy,
   output uop_type  pop_data
);

   uop_type               slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]      count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_rdy = (count_ff != (Q_PTR_W+1)'(Q_DEPTH));
   assign pop_vld  = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push_vld && push_rdy;
   assign do_pop   = pop_vld && pop_rdy;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/ttw_back.sv
// Back end: owns the screen memory, cursor and registers; carries out
// micro-operations, scrolls and returns one result beat per item. Uses ttw_pkg.
module ttw_back
   import ttw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_vld,
   output logic          pop_rdy,
   input  uop_type       pop_data,
   output logic          ready_out,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [7:0]    csr_data,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 cp_vld_ff, cp_vld_in;
   logic [IDX_W-1:0]     cp_addr_ff, cp_addr_in;
   logic [IDX_W-1:0]     kept_ff, kept_in;
   logic [IDX_W-1:0]     off_ff, off_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 pend_ff, pend_in;
   logic                 rd_sel_ff, rd_sel_in;
   logic [CLR_W-1:0]     color_ff, color_in;
   logic [SCRL_W-1:0]    scroll_ff, scroll_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   logic [CELL_W-1:0]    scr_mem [CELL_CNT];
   logic [CELL_W-1:0]    rdata_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   logic [CELL_W-1:0]    mem_wd;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_ra;

   logic                 out_free;
   logic [IDX_W-1:0]     cur_addr;
   logic [COL_W-1:0]     col_nx;
   logic [ROW_W-1:0]     row_nx;
   logic [ROW_W-1:0]     lines;
   logic                 do_nl;

   assign csr_ready  = 1'b1;
   assign ready_out  = (state_ff != ST_CLEAR);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign cur_addr   = IDX_W'(row_ff) * IDX_W'(SCR_COLS) + IDX_W'(col_ff);
   assign col_nx     = col_ff + 1'b1;
   assign row_nx     = row_ff + 1'b1;

   // Clamp the scroll amount to one screen; a zero amount scrolls one row
   always_comb begin
      if (scroll_ff == '0) begin
         lines = ROW_W'(1);
      end else if (scroll_ff > SCRL_W'(SCR_ROWS)) begin
         lines = ROW_W'(SCR_ROWS);
      end else begin
         lines = ROW_W'(scroll_ff);
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cp_vld_in   = 1'b0;
      cp_addr_in  = cp_addr_ff;
      kept_in     = kept_ff;
      off_in      = off_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pend_in     = pend_ff;
      rd_sel_in   = rd_sel_ff;
      color_in    = color_ff;
      scroll_in   = scroll_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      mem_wa      = cnt_ff;
      mem_wd      = {color_ff, BLANK_CHAR};
      mem_re      = 1'b0;
      mem_ra      = pop_data.cell_index;
      pop_rdy     = 1'b0;
      do_nl       = 1'b0;

      // Drop the result beat once taken
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_TEXT_COLOR:   color_in  = csr_data[CLR_W-1:0];
            CSR_SCROLL_LINES: scroll_in = csr_data[SCRL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = {RESET_COLOR, BLANK_CHAR};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(CELL_CNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (pop_vld) begin
               pop_rdy   = 1'b1;
               pend_in   = pop_data.last;
               rd_sel_in = 1'b0;
               state_in  = pop_data.last ? ST_RESP : ST_EXEC;
               case (pop_data.op)
                  OP_PRINT: begin
                     mem_we = 1'b1;
                     mem_wa = cur_addr;
                     mem_wd = {color_ff, pop_data.char_code};
                     if (col_nx == COL_W'(SCR_COLS)) begin
                        do_nl = 1'b1;
                     end else begin
                        col_in = col_nx;
                     end
                  end
                  OP_NEWLINE: do_nl = 1'b1;
                  OP_RETURN:  col_in = '0;
                  OP_BACK: begin
                     if (row_ff != '0 || col_ff != '0) begin
                        mem_we = 1'b1;
                        mem_wa = cur_addr - 1'b1;
                        mem_wd = {color_ff, ERASE_CHAR};
                        if (col_ff == '0) begin
                           col_in = COL_W'(SCR_COLS - 1);
                           row_in = row_ff - 1'b1;
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (pop_data.cell_index < IDX_W'(CELL_CNT)) begin
                        mem_re    = 1'b1;
                        rd_sel_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               // Newline, scrolling when passing the bottom row
               if (do_nl) begin
                  col_in = '0;
                  if (row_nx == ROW_W'(SCR_ROWS)) begin
                     row_in   = ROW_W'(SCR_ROWS) - lines;
                     kept_in  = IDX_W'(ROW_W'(SCR_ROWS) - lines) * IDX_W'(SCR_COLS);
                     off_in   = IDX_W'(lines) * IDX_W'(SCR_COLS);
                     cnt_in   = '0;
                     state_in = ST_COPY;
                  end else begin
                     row_in = row_nx;
                  end
               end
            end
         end
         ST_COPY: begin
            // Read the cell the scroll amount of rows ahead, write it back in the next cycle
            if (cnt_ff < kept_ff) begin
               mem_re     = 1'b1;
               mem_ra     = cnt_ff + off_ff;
               cp_vld_in  = 1'b1;
               cp_addr_in = cnt_ff;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_FILL;
            end
            if (cp_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = cp_addr_ff;
               mem_wd = rdata_ff;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(CELL_CNT - 1)) begin
               cnt_in   = '0;
               state_in = pend_ff ? ST_RESP : ST_EXEC;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {1'b0, cur_addr, row_ff, col_ff,
                              rd_sel_ff ? rdata_ff : CELL_W'(0)};
               state_in    = ST_EXEC;
            end
         end
         default: state_in = ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         cp_vld_ff  <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         color_ff   <= RESET_COLOR;
         scroll_ff  <= RESET_SCROLL;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cp_vld_ff  <= cp_vld_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         color_ff   <= color_in;
         scroll_ff  <= scroll_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cp_addr_ff  <= cp_addr_in;
      kept_ff     <= kept_in;
      off_ff      <= off_in;
      pend_ff     <= pend_in;
      rd_sel_ff   <= rd_sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         scr_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= scr_mem[mem_ra];
      end
   end

endmodule

>>> rtl/core/text_terminal_writer_top.sv
// Text terminal writer, 80x25 cells. An accepted beat passes the front's
// hold register, the queue and the back end's execute and result states
// before its result beat; the front takes a new beat while the back end
// still works on earlier items, as long as the queue has room. An escaped
// byte becomes four print operations. A scroll moves one cell per cycle.
// After reset a clearing pass runs; req_tready stays low until it ends.
module text_terminal_writer_top
   import ttw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // char_code[7:0], cell_index[18:8]
   input  logic          req_tuser,   // mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,   // cell_data[15:0], cursor_column[22:16],
                                      // cursor_row[27:23], cursor_position[38:28]
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [7:0]    csr_data
);

   logic      push_vld;
   logic      push_rdy;
   uop_type   push_data;
   logic      pop_vld;
   logic      pop_rdy;
   uop_type   pop_data;
   logic      back_ready;

   ttw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (back_ready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_vld   (push_vld),
      .push_rdy   (push_rdy),
      .push_data  (push_data)
   );

   ttw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_rdy  (push_rdy),
      .push_data (push_data),
      .pop_vld   (pop_vld),
      .pop_rdy   (pop_rdy),
      .pop_data  (pop_data)
   );

   ttw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_vld    (pop_vld),
      .pop_rdy    (pop_rdy),
      .pop_data   (pop_data),
      .ready_out  (back_ready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> verif/text_terminal_writer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_terminal_writer_top: a shadow terminal predicts each
// result beat from the accepted request beats. Depends on ttw_pkg and the top level only.
module text_terminal_writer_top_tb;
   import ttw_pkg::*;

   // Request modes and the character codes the terminal treats specially
   localparam logic              MODE_PUT     = 1'b0;
   localparam logic              MODE_READ    = 1'b1;
   localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] PRINT_LO     = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_HI     = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_X         = 8'h78;
   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_A      = 8'h61;
   localparam int                IDX_MAX      = (1 << IDX_W) - 1;

   typedef struct {
      logic              mode;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
      int                cursor_back;   // >= 0: read this many cells behind the cursor
   } term_item_type;

   typedef struct {
      logic [CELL_W-1:0] cell_data;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [IDX_W-1:0]  pos;
   } cursor_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = '0;   // char_code[7:0], cell_index[18:8]
   logic              req_tuser = 1'b0; // mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;        // cell_data[15:0], cursor_column[22:16],
                                        // cursor_row[27:23], cursor_position[38:28]
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [7:0]        csr_data = '0;

   // Shadow terminal
   logic [CELL_W-1:0] shadow_screen [CELL_CNT];
   int                shadow_col;
   int                shadow_row;
   logic [CLR_W-1:0]  shadow_color;
   logic [SCRL_W-1:0] shadow_scroll;

   term_item_type       pending_items [$];
   cursor_report_type   cursor_reports [$];
   term_item_type       beat_in_flight;
   term_item_type       next_item;
   cursor_report_type   arrived;
   int                items_queued = 0;
   int                items_accepted = 0;
   int                fail_count = 0;
   int                send_idle_pct = 30;
   int                recv_idle_pct = 30;

   text_terminal_writer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
      if (nib < 4'd10) return ASCII_ZERO + {4'h0, nib};
      return ASCII_A + {4'h0, nib - 4'd10};
   endfunction

   // Move to the start of the next row, scrolling once the bottom is passed
   function automatic void line_feed();
      int lines;
      int kept;
      shadow_col = 0;
      shadow_row++;
      if (shadow_row >= SCR_ROWS) begin
         lines = int'(shadow_scroll);
         if (lines == 0) lines = 1;
         if (lines > SCR_ROWS) lines = SCR_ROWS;
         kept = (SCR_ROWS - lines) * SCR_COLS;
         for (int i = 0; i < CELL_CNT; i++) begin
            if (i < kept) shadow_screen[i] = shadow_screen[i + lines * SCR_COLS];
            else shadow_screen[i] = {shadow_color, BLANK_CHAR};
         end
         shadow_row = SCR_ROWS - lines;
      end
   endfunction

   function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
      shadow_screen[shadow_row * SCR_COLS + shadow_col] = {shadow_color, ch};
      shadow_col++;
      if (shadow_col >= SCR_COLS) line_feed();
   endfunction

   // Update the shadow terminal with one request and return the result it gives
   function automatic cursor_report_type apply_terminal_item(input term_item_type it);
      cursor_report_type rep;
      rep.cell_data = '0;
      if (it.mode == MODE_READ) begin
         if (it.cell_index < CELL_CNT) rep.cell_data = shadow_screen[it.cell_index];
      end else begin
         case (it.char_code)
            CH_LF: line_feed();
            CH_CR: shadow_col = 0;
            CH_BS: begin
               if (shadow_row != 0 || shadow_col != 0) begin
                  if (shadow_col == 0) begin
                     shadow_col = SCR_COLS - 1;
                     shadow_row--;
                  end else begin
                     shadow_col--;
                  end
                  shadow_screen[shadow_row * SCR_COLS + shadow_col] = {shadow_color, ERASE_CHAR};
               end
            end
            default: begin
               if (it.char_code >= PRINT_LO && it.char_code <= PRINT_HI) begin
                  put_glyph(it.char_code);
               end else begin
                  put_glyph(CH_BACKSLASH);
                  put_glyph(CH_X);
                  put_glyph(hex_glyph(it.char_code[7:4]));
                  put_glyph(hex_glyph(it.char_code[3:0]));
               end
            end
         endcase
      end
      rep.col = COL_W'(shadow_col);
      rep.row = ROW_W'(shadow_row);
      rep.pos = IDX_W'(shadow_row * SCR_COLS + shadow_col);
      return rep;
   endfunction

   function automatic term_item_type put_item(input logic [CHAR_W-1:0] code);
      term_item_type it;
      it.mode = MODE_PUT;
      it.char_code = code;
      it.cell_index = IDX_W'($urandom);
      it.cursor_back = -1;
      return it;
   endfunction

   function automatic term_item_type read_item(input int idx, input int back);
      term_item_type it;
      it.mode = MODE_READ;
      it.char_code = CHAR_W'($urandom);
      it.cell_index = IDX_W'(idx);
      it.cursor_back = back;
      return it;
   endfunction

   // Mostly printable text and line control, some escaped bytes and reads
   function automatic term_item_type random_item();
      int pick;
      int r;
      pick = $urandom_range(99);
      if (pick < 40) return put_item(CHAR_W'($urandom_range(PRINT_HI, PRINT_LO)));
      if (pick < 52) return put_item(CH_LF);
      if (pick < 57) return put_item(CH_CR);
      if (pick < 65) return put_item(CH_BS);
      if (pick < 77) begin
         // 0x00..0x1F or 0x7F..0xFF
         r = $urandom_range(160);
         return put_item(CHAR_W'((r < 32) ? r : r + 8'h5F));
      end
      r = $urandom_range(9);
      if (r < 5) return read_item(0, $urandom_range(9));
      if (r < 9) return read_item($urandom_range(CELL_CNT - 1), -1);
      return read_item($urandom_range(IDX_MAX, CELL_CNT), -1);
   endfunction

   task automatic enqueue(input term_item_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || cursor_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TEXT_COLOR) shadow_color = val;
      else shadow_scroll = val[SCRL_W-1:0];
   endtask

   task automatic run_phase(input logic [7:0] color, input logic [7:0] scroll,
                            input int count, input int idle);
      wait_drained();
      write_csr(CSR_TEXT_COLOR, color);
      write_csr(CSR_SCROLL_LINES, scroll);
      send_idle_pct = idle;
      recv_idle_pct = idle;
      repeat (count) enqueue(random_item());
   endtask

   function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
                                       input logic [CELL_W-1:0] got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Request driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         for (int i = 0; i < CELL_CNT; i++) shadow_screen[i] = {RESET_COLOR, BLANK_CHAR};
         shadow_col = 0;
         shadow_row = 0;
         shadow_color = RESET_COLOR;
         shadow_scroll = RESET_SCROLL;
      end else begin
         if (req_tvalid && req_tready) begin
            cursor_reports.push_back(apply_terminal_item(beat_in_flight));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               if (next_item.cursor_back >= 0)
                  next_item.cell_index = IDX_W'((shadow_row * SCR_COLS + shadow_col
                                          + CELL_CNT - next_item.cursor_back) % CELL_CNT);
               beat_in_flight = next_item;
               req_tdata  <= {5'b0, next_item.cell_index, next_item.char_code};
               req_tuser  <= next_item.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cursor_reports.size() == 0) begin
               $error("result beat with no request outstanding: 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               arrived = cursor_reports.pop_front();
               check_field("cell_data", arrived.cell_data, rsp_tdata[15:0]);
               check_field("cursor_column", CELL_W'(arrived.col),
                           CELL_W'(rsp_tdata[22:16]));
               check_field("cursor_row", CELL_W'(arrived.row), CELL_W'(rsp_tdata[27:23]));
               check_field("cursor_position", CELL_W'(arrived.pos),
                           CELL_W'(rsp_tdata[38:28]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: origin backspace, character extremes, escapes, erase, wrap, reads
      enqueue(put_item(CH_BS));
      enqueue(read_item(0, -1));
      enqueue(put_item(8'h41));
      enqueue(put_item(PRINT_LO));
      enqueue(put_item(PRINT_HI));
      enqueue(put_item(8'h00));
      enqueue(put_item(8'hFF));
      enqueue(put_item(8'h1F));
      enqueue(put_item(8'h7F));
      enqueue(put_item(8'h09));
      enqueue(read_item(0, -1));
      enqueue(read_item(6, -1));
      enqueue(put_item(CH_BS));
      enqueue(read_item(0, 0));
      enqueue(put_item(CH_CR));
      enqueue(put_item(CH_LF));
      enqueue(put_item(CH_BS));
      enqueue(read_item(0, 0));
      enqueue(read_item(CELL_CNT - 1, -1));
      enqueue(read_item(CELL_CNT, -1));
      enqueue(read_item(IDX_MAX, -1));
      enqueue(put_item(CH_LF));

      // Random phases over colour and scroll settings, out-of-range scrolls included
      run_phase(8'h1F, 8'd1, 200, 30);
      run_phase(8'hFF, 8'd24, 200, 0);
      run_phase(8'h00, 8'd0, 150, 30);
      run_phase(CLR_W'($urandom), 8'd31, 200, 30);
      run_phase(8'hA5, 8'hE5, 150, 30);
      run_phase(8'h70, 8'd25, 150, 30);

      wait_drained();
      repeat (20) @(posedge clock);
      if (cursor_reports.size() != 0) begin
         $error("%0d results never arrived", cursor_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
